[sv/text_console_writer_macros.svh]
// Assertion macros shared by the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] CmdPut   = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] ResetAttr   = 8'h0F;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } rsp_t;

endpackage

`default_nettype wire

[sv/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/tcw_engine.sv]
// Sequencer, cursor and sweep address unit driving the cell store.
`default_nettype none

module tcw_engine #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tcw_pkg::req_t req_data,
  input  wire logic [7:0]    attr,
  output logic               res_valid,
  output tcw_pkg::rsp_t      res,
  input  wire logic          res_take
);

  localparam int Cells = ROWS * COLS;
  localparam int AW    = $clog2(Cells);
  localparam int SW    = $clog2(Cells + 1);
  localparam int CLW   = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CmpW  = (AW > 11) ? AW : 11;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCopy  = 3'd2;
  localparam logic [2:0] StBlank = 3'd3;
  localparam logic [2:0] StClear = 3'd4;
  localparam logic [2:0] StInit  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]     state, state_next;
  logic [SW-1:0]  sweep, sweep_next;
  logic [AW-1:0]  dst, dst_next;
  logic           cp_wr, cp_wr_next;
  logic [CLW-1:0] col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [AW-1:0]  pos, pos_next;
  logic [15:0]    res_cell, res_cell_next;
  logic           res_scr, res_scr_next;

  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;
  logic [SW-1:0]  sweep_inc;
  logic           do_nl;

  tcw_ram #(
    .Width(16),
    .Depth(Cells)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sweep_inc = sweep + SW'(1);
  assign req_ready = (state == StIdle);
  assign res_valid = (state == StDone);

  always_comb begin
    res.cursor_col = 7'(col);
    res.cursor_row = 5'(row);
    res.cursor_pos = 11'(pos);
    res.cell_value = res_cell;
    res.scrolled   = res_scr;
  end

  always_comb begin
    state_next    = state;
    sweep_next    = sweep;
    dst_next      = dst;
    cp_wr_next    = 1'b0;
    col_next      = col;
    row_next      = row;
    pos_next      = pos;
    res_cell_next = res_cell;
    res_scr_next  = res_scr;
    we            = 1'b0;
    waddr         = sweep[AW-1:0];
    wdata         = {attr, tcw_pkg::BlankChar};
    re            = 1'b0;
    raddr         = sweep[AW-1:0];
    do_nl         = 1'b0;

    case (state)
      StIdle: begin
        if (req_valid) begin
          res_cell_next = 16'h0000;
          res_scr_next  = 1'b0;
          state_next    = StDone;
          case (req_data.cmd)
            tcw_pkg::CmdPut: begin
              if (req_data.ch == tcw_pkg::NewlineChar) begin
                do_nl = 1'b1;
              end else begin
                we    = 1'b1;
                waddr = pos;
                wdata = {attr, req_data.ch};
                if (col == CLW'(COLS - 1)) begin
                  do_nl = 1'b1;
                end else begin
                  col_next = col + CLW'(1);
                  pos_next = pos + AW'(1);
                end
              end
              if (do_nl) begin
                col_next = '0;
                if (row == RW'(ROWS - 1)) begin
                  // Bottom passed: park on the last row and start the scroll.
                  pos_next     = AW'((ROWS - 1) * COLS);
                  res_scr_next = 1'b1;
                  sweep_next   = SW'(COLS);
                  state_next   = StCopy;
                end else begin
                  row_next = row + RW'(1);
                  pos_next = AW'(pos - AW'(col) + AW'(COLS));
                end
              end
            end
            tcw_pkg::CmdClear: begin
              col_next   = '0;
              row_next   = '0;
              pos_next   = '0;
              sweep_next = '0;
              state_next = StClear;
            end
            tcw_pkg::CmdRead: begin
              if (CmpW'(req_data.cell_index) < CmpW'(Cells)) begin
                re         = 1'b1;
                raddr      = AW'(req_data.cell_index);
                state_next = StRead;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        res_cell_next = rdata;
        state_next    = StDone;
      end
      StCopy: begin
        // Read one row below, write it back in the next cycle one row up.
        we    = cp_wr;
        waddr = dst;
        wdata = rdata;
        if (sweep != SW'(Cells)) begin
          re         = 1'b1;
          dst_next   = AW'(sweep - SW'(COLS));
          cp_wr_next = 1'b1;
          sweep_next = sweep_inc;
        end else begin
          sweep_next = SW'((ROWS - 1) * COLS);
          state_next = StBlank;
        end
      end
      StBlank, StClear, StInit: begin
        we = 1'b1;
        if (state == StInit) begin
          wdata = {tcw_pkg::ResetAttr, tcw_pkg::BlankChar};
        end
        if (sweep == SW'(Cells - 1)) begin
          state_next = (state == StInit) ? StIdle : StDone;
        end else begin
          sweep_next = sweep_inc;
        end
      end
      StDone: begin
        if (res_take) begin
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StInit;
      sweep <= '0;
      cp_wr <= 1'b0;
      col   <= '0;
      row   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      cp_wr <= cp_wr_next;
      col   <= col_next;
      row   <= row_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    dst      <= dst_next;
    res_cell <= res_cell_next;
    res_scr  <= res_scr_next;
  end

endmodule

`default_nettype wire

[sv/text_console_writer.sv]
// Text console writer top level: attribute register, sequencer, result register.
// A put that scrolls adds a row copy and a bottom-row blank sweep; a clear blanks
// every cell in one sweep.
// Throughput: one item at a time; the single store write
// port and the sweep address unit set the sweep lengths, one cell per cycle.
// Reset: synchronous; a blanking pass over all ROWS*COLS cells follows, req_ready low.
`default_nettype none

module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tcw_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tcw_pkg::rsp_t      rsp_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data
);

  logic          res_valid;
  logic          res_take;
  tcw_pkg::rsp_t res;
  logic [7:0]    attr;

  // Attribute register: always writable, used for every put and every scroll or clear blank.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ResetAttr;
    end else if (cfg_valid) begin
      attr <= cfg_data;
    end
  end

  tcw_engine #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .attr     (attr),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  // Move the finished item into the output register once it is free.
  assign res_take = res_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; load only on take.
  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_data <= res;
    end
  end

endmodule

`default_nettype wire

[sv/tcw_checker.sv]
// Port-level assertions for the text console writer, bound to its top level.
`default_nettype none

`include "text_console_writer_macros.svh"

module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire tcw_pkg::rsp_t rsp_data
);

  `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

  `TCW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "item accepted while previous still at work")

  `TCW_ASSERT_NOW(a_scroll_col, rsp_valid && rsp_data.scrolled, rsp_data.cursor_col == 7'd0, "scroll left cursor off column zero")

  `TCW_ASSERT_NOW(a_scroll_row, rsp_valid && rsp_data.scrolled, rsp_data.cursor_row == 5'(ROWS - 1), "scroll left cursor off last row")

endmodule

bind text_console_writer tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp_data (rsp_data)
);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the text console writer: directed and random commands, live prediction.
module testbench;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = ROWS * COLS;
  // The index field spans 2048 values; anything at or past CELLS reads as zero.
  localparam int IndexSpan = 2048;
  // The command encoding the block leaves unused; it must change nothing.
  localparam logic [1:0] CmdUnused = 2'd3;
  // Slowest legal gap between handshakes is a scroll or clear sweep over every
  // cell plus a long stall on either side; allow several times that.
  localparam int StuckLimit = 12000;
  localparam int PhaseItems = 150;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  tcw_pkg::req_t req_data = '0;
  logic rsp_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic req_ready;
  logic rsp_valid;
  tcw_pkg::rsp_t rsp_data;
  logic cfg_ready;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the console: cell store, cursor and current attribute.
  logic [15:0] screen [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0] attr_now;

  // Commands waiting to be driven, and cursor reports owed by the block.
  tcw_pkg::req_t cmd_backlog [$];
  tcw_pkg::rsp_t cursor_reports [$];
  tcw_pkg::rsp_t want;

  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned live_queued;
  int unsigned n_put, n_clear, n_read, n_unused, n_scroll;
  int unsigned attr_writes, results_seen, errors;

  logic req_took = 1'b0;
  logic cfg_took = 1'b0;
  int unsigned send_gap = 0;
  int unsigned take_stall = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b1;
  int unsigned stuck_cycles = 0;

  function automatic void blank_screen(logic [7:0] attr);
    for (int i = 0; i < CELLS; i++) screen[i] = {attr, tcw_pkg::BlankChar};
  endfunction

  // Drop to column 0 of the next row; at the bottom, shift every row up and
  // blank the last one with the current attribute. Report whether it scrolled.
  function automatic logic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      screen[i] = {attr_now, tcw_pkg::BlankChar};
    end
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  // Apply one accepted command to the shadow and return the report it owes.
  function automatic tcw_pkg::rsp_t console_apply(tcw_pkg::req_t r);
    tcw_pkg::rsp_t o;
    int unsigned pos;
    o = '0;
    case (r.cmd)
      tcw_pkg::CmdPut: begin
        n_put++;
        if (r.ch == tcw_pkg::NewlineChar) begin
          o.scrolled = line_feed();
        end else begin
          screen[cur_row * COLS + cur_col] = {attr_now, r.ch};
          cur_col++;
          if (cur_col >= COLS) o.scrolled = line_feed();
        end
      end
      tcw_pkg::CmdClear: begin
        n_clear++;
        blank_screen(attr_now);
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::CmdRead: begin
        n_read++;
        if (r.cell_index < CELLS) o.cell_value = screen[r.cell_index];
      end
      default: begin
        n_unused++;
      end
    endcase
    if (o.scrolled) n_scroll++;
    pos = cur_row * COLS + cur_col;
    o.cursor_col = 7'(cur_col);
    o.cursor_row = 5'(cur_row);
    o.cursor_pos = 11'(pos);
    return o;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      errors++;
    end
  endtask

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bias reads toward the top rows and the bottom rows, where text lands.
  function automatic logic [10:0] read_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 11'($urandom_range(0, 3 * COLS - 1));
      4, 5, 6:    return 11'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
      7, 8:       return 11'($urandom_range(0, CELLS - 1));
      default:    return 11'($urandom_range(CELLS, IndexSpan - 1));
    endcase
  endfunction

  task automatic queue_item(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
    tcw_pkg::req_t r;
    r.cmd = cmd;
    r.ch = ch;
    r.cell_index = idx;
    cmd_backlog.push_back(r);
    items_queued++;
    if (cmd != CmdUnused) live_queued++;
  endtask

  // Mostly lines of text ending in a newline, with reads mixed in; the rest
  // is read bursts, clears, unused commands and fully random noise.
  task automatic queue_random_phase(int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0] ch;
    start = live_queued;
    while (live_queued - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(COLS - 2, COLS + 1)
                                          : $urandom_range(0, 12);
        repeat (len) begin
          ch = 8'($urandom());
          if (ch == tcw_pkg::NewlineChar) ch = tcw_pkg::BlankChar;
          queue_item(tcw_pkg::CmdPut, ch, 11'($urandom()));
          if ($urandom_range(0, 7) == 0) begin
            queue_item(tcw_pkg::CmdRead, 8'($urandom()), read_index());
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          queue_item(tcw_pkg::CmdPut, tcw_pkg::NewlineChar, 11'($urandom()));
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) queue_item(tcw_pkg::CmdRead, 8'($urandom()), read_index());
      end else if (pick < 83) begin
        queue_item(tcw_pkg::CmdClear, 8'($urandom()), 11'($urandom()));
      end else if (pick < 88) begin
        queue_item(CmdUnused, 8'($urandom()), 11'($urandom()));
      end else begin
        queue_item(2'($urandom()), 8'($urandom()), 11'($urandom()));
      end
    end
  endtask

  // Hold until every queued command is taken and every report is back.
  task automatic wait_quiet();
    @(negedge clk);
    while (items_taken != items_queued || cursor_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Command driver: hold the item until taken, then idle or advance.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_took) begin
      // hold payload and valid until the handshake
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      req_valid <= 1'b0;
    end else if (cmd_backlog.size() != 0) begin
      req_data <= cmd_backlog.pop_front();
      req_valid <= 1'b1;
      send_gap <= pick_gap(send_calm);
    end else begin
      req_valid <= 1'b0;
    end
    if ($urandom_range(0, 255) == 0) send_calm <= !send_calm;
  end

  // Report receiver: stall at random, with calm stretches of steady ready.
  always @(negedge clk) begin
    if (take_stall != 0) begin
      rsp_ready <= 1'b0;
      take_stall <= take_stall - 1;
    end else begin
      rsp_ready <= 1'b1;
      take_stall <= pick_gap(take_calm);
    end
    if ($urandom_range(0, 255) == 0) take_calm <= !take_calm;
  end

  // Monitor: sample every handshake at the rising edge, predict and compare.
  always @(posedge clk) begin
    req_took <= !rst && req_valid && req_ready;
    cfg_took <= !rst && cfg_valid && cfg_ready;
    if (!rst && cfg_valid && cfg_ready) begin
      attr_now = cfg_data;
      attr_writes++;
    end
    // Retire the report before predicting a newly taken command.
    if (!rst && rsp_valid && rsp_ready) begin
      if (cursor_reports.size() == 0) begin
        $error("cursor report arrived with no command outstanding");
        errors++;
      end else begin
        want = cursor_reports.pop_front();
        check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_data.cursor_col));
        check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_data.cursor_row));
        check_field("cursor_pos", 16'(want.cursor_pos), 16'(rsp_data.cursor_pos));
        check_field("cell_value", want.cell_value, rsp_data.cell_value);
        check_field("scrolled", 16'(want.scrolled), 16'(rsp_data.scrolled));
        results_seen++;
      end
    end
    if (!rst && req_valid && req_ready) begin
      cursor_reports.push_back(console_apply(req_data));
      items_taken++;
    end
  end

  // Watchdog: end the run if no item moves on any channel for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("Watchdog: no item moved for %0d cycles", stuck_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] attr_plan [6];
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = 8'($urandom_range(1, 254));
    attr_plan[3] = 8'h70;
    attr_plan[4] = 8'($urandom_range(1, 254));
    attr_plan[5] = tcw_pkg::ResetAttr;

    blank_screen(tcw_pkg::ResetAttr);
    attr_now = tcw_pkg::ResetAttr;
    cur_col = 0;
    cur_row = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: blank reads at both ends and out of range, extreme bytes,
    // newline, ignored fields, the unused command, then clear and re-read.
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'd0);
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'(CELLS - 1));
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'(CELLS));
    queue_item(tcw_pkg::CmdRead, 8'hFF, 11'(IndexSpan - 1));
    queue_item(tcw_pkg::CmdPut, 8'h00, 11'(IndexSpan - 1));
    queue_item(tcw_pkg::CmdPut, 8'hFF, 11'd0);
    queue_item(tcw_pkg::CmdPut, 8'h41, 11'h555);
    queue_item(tcw_pkg::CmdPut, tcw_pkg::NewlineChar, 11'h2AA);
    queue_item(tcw_pkg::CmdRead, 8'h0A, 11'd0);
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'd1);
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'd2);
    queue_item(CmdUnused, 8'hFF, 11'(IndexSpan - 1));
    queue_item(CmdUnused, 8'h00, 11'd0);
    queue_item(tcw_pkg::CmdPut, tcw_pkg::NewlineChar, 11'd0);
    queue_item(tcw_pkg::CmdPut, 8'h5A, 11'd0);
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'(2 * COLS));
    queue_item(tcw_pkg::CmdClear, 8'hFF, 11'(IndexSpan - 1));
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'd0);
    queue_item(tcw_pkg::CmdRead, 8'h00, 11'(2 * COLS));
    wait_quiet();

    // Random phases, each under a fresh attribute written while idle.
    foreach (attr_plan[k]) begin
      write_attr(attr_plan[k]);
      queue_random_phase(PhaseItems);
      wait_quiet();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d puts, %0d clears, %0d reads, %0d unused commands, %0d scrolls",
             n_put, n_clear, n_read, n_unused, n_scroll);
    $display("%0d attribute writes, %0d reports checked, %0d mismatches",
             attr_writes, results_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_engine.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
bench/testbench.sv
